FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the task queue block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that forces another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tqu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task queue package
// Sizes, operation and status codes, and id helper for the task queue block.
// ----------------------------------------------------------------------------
package tqu_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int HISTORY_DEPTH = 16;
  localparam int ID_WIDTH      = 16;
  localparam int TAG_WIDTH     = 32;

  localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int HADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ENTRY_W = ID_WIDTH + TAG_WIDTH;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_RESTORE  = 2'd1,
    MODE_COMPLETE = 2'd2,
    MODE_UNDO     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QEMPTY = 2'd1,
    ST_HEMPTY = 2'd2,
    ST_QFULL  = 2'd3
  } status_t;

  // Next id after the given one; the wrap lands on 1 since 0 is never issued.
  function automatic logic [ID_WIDTH-1:0] bump_id(input logic [ID_WIDTH-1:0] id);
    logic [ID_WIDTH-1:0] n;
    n = id + ID_WIDTH'(1);
    return (n == '0) ? ID_WIDTH'(1) : n;
  endfunction

endpackage

FILE: hdl/tqu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task queue channels
// Request and response channels with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface tqu_req_if;
  import tqu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [ID_WIDTH-1:0]  task_id;
  logic [TAG_WIDTH-1:0] task_tag;

  modport source (output valid, mode, task_id, task_tag, input ready);
  modport sink   (input valid, mode, task_id, task_tag, output ready);
endinterface

interface tqu_rsp_if;
  import tqu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ID_WIDTH-1:0]  result_id;
  logic [TAG_WIDTH-1:0] result_tag;
  logic [1:0]           status;
  logic [QCNT_W-1:0]    pending_count;
  logic [HCNT_W-1:0]    history_count;

  modport source (output valid, result_id, result_tag, status, pending_count,
                  history_count, input ready);
  modport sink   (input valid, result_id, result_tag, status, pending_count,
                  history_count, output ready);
endinterface

FILE: hdl/tqu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tqu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/task_queue_with_undo_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task queue with undo stack
// FIFO of pending tasks and LIFO history of completed tasks, both in RAM.
// ----------------------------------------------------------------------------
// Add and restore write the entry at the queue tail in the cycle of the
// transfer and register the result at once. Complete and undo read the RAM
// (queue head for complete, history top for undo) in the cycle of the
// transfer; in the S_WAIT state the registered read data is written into
// the other RAM and the result is registered. One item is in work at a
// time, and a new request is taken in the same cycle as the previous result
// is transferred. Pointers and counts live in flip-flops, so the RAMs need no
// clearing pass after reset. A full history drops its oldest entry on
// complete; empty and full cases return a status code with id and tag of 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module task_queue_with_undo_stack (
  input logic     clk,
  input logic     rst,
  tqu_req_if.sink req,
  tqu_rsp_if.source rsp
);
  import tqu_pkg::*;

  typedef enum logic {S_IDLE, S_WAIT} state_t;

  // Control and pointer registers.
  state_t               state, state_next;
  logic [QADDR_W-1:0]   queue_head, queue_head_next;
  logic [QADDR_W-1:0]   queue_tail, queue_tail_next;
  logic [QCNT_W-1:0]    queue_fill, queue_fill_next;
  logic [HADDR_W-1:0]   history_top, history_top_next;
  logic [HCNT_W-1:0]    history_fill, history_fill_next;
  logic [ID_WIDTH-1:0]  next_id, next_id_next;
  logic                 pend_undo, pend_undo_next;
  logic [QADDR_W-1:0]   wq_addr, wq_addr_next;
  logic [HADDR_W-1:0]   wh_addr, wh_addr_next;

  // Output register.
  logic                 out_valid, out_valid_next;
  logic [ID_WIDTH-1:0]  out_id, out_id_next;
  logic [TAG_WIDTH-1:0] out_tag, out_tag_next;
  status_t              out_status, out_status_next;
  logic [QCNT_W-1:0]    out_pcount, out_pcount_next;
  logic [HCNT_W-1:0]    out_hcount, out_hcount_next;

  // RAM ports.
  logic                 q_we, q_re, h_we, h_re;
  logic [QADDR_W-1:0]   q_waddr, q_raddr;
  logic [HADDR_W-1:0]   h_waddr, h_raddr;
  logic [ENTRY_W-1:0]   q_wdata, q_rdata, h_wdata, h_rdata;

  logic                 acc;
  logic                 q_full;
  logic [QADDR_W-1:0]   tail_inc, head_inc;
  logic [HADDR_W-1:0]   top_inc, top_dec;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign q_full    = (queue_fill == QCNT_W'(QUEUE_DEPTH));

  assign tail_inc = (queue_tail == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : queue_tail + QADDR_W'(1);
  assign head_inc = (queue_head == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : queue_head + QADDR_W'(1);
  assign top_inc  = (history_top == HADDR_W'(HISTORY_DEPTH - 1)) ? '0
                    : history_top + HADDR_W'(1);
  assign top_dec  = (history_top == '0) ? HADDR_W'(HISTORY_DEPTH - 1)
                    : history_top - HADDR_W'(1);

  // Operation decode, pointer update and result selection.
  always_comb begin
    state_next        = state;
    queue_head_next   = queue_head;
    queue_tail_next   = queue_tail;
    queue_fill_next   = queue_fill;
    history_top_next  = history_top;
    history_fill_next = history_fill;
    next_id_next      = next_id;
    pend_undo_next    = pend_undo;
    wq_addr_next      = wq_addr;
    wh_addr_next      = wh_addr;
    out_valid_next    = out_valid && !rsp.ready;
    out_id_next       = out_id;
    out_tag_next      = out_tag;
    out_status_next   = out_status;
    out_pcount_next   = out_pcount;
    out_hcount_next   = out_hcount;
    q_we    = 1'b0;
    q_waddr = queue_tail;
    q_wdata = {next_id, req.task_tag};
    q_re    = 1'b0;
    q_raddr = queue_head;
    h_we    = 1'b0;
    h_waddr = wh_addr;
    h_wdata = q_rdata;
    h_re    = 1'b0;
    h_raddr = top_dec;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          out_id_next     = '0;
          out_tag_next    = '0;
          out_status_next = ST_OK;
          unique case (mode_t'(req.mode))
            MODE_ADD, MODE_RESTORE: begin
              if (q_full) begin
                out_status_next = ST_QFULL;
              end else begin
                q_we            = 1'b1;
                queue_tail_next = tail_inc;
                queue_fill_next = queue_fill + QCNT_W'(1);
                out_tag_next    = req.task_tag;
                if (mode_t'(req.mode) == MODE_ADD) begin
                  out_id_next  = next_id;
                  next_id_next = bump_id(next_id);
                end else begin
                  q_wdata     = {req.task_id, req.task_tag};
                  out_id_next = req.task_id;
                  if (req.task_id >= next_id) begin
                    next_id_next = bump_id(req.task_id);
                  end
                end
              end
            end
            MODE_COMPLETE: begin
              if (queue_fill == '0) begin
                out_status_next = ST_QEMPTY;
              end else begin
                q_re             = 1'b1;
                queue_head_next  = head_inc;
                queue_fill_next  = queue_fill - QCNT_W'(1);
                wh_addr_next     = history_top;
                history_top_next = top_inc;
                if (history_fill != HCNT_W'(HISTORY_DEPTH)) begin
                  history_fill_next = history_fill + HCNT_W'(1);
                end
                pend_undo_next = 1'b0;
                state_next     = S_WAIT;
              end
            end
            MODE_UNDO: begin
              if (history_fill == '0) begin
                out_status_next = ST_HEMPTY;
              end else if (q_full) begin
                out_status_next = ST_QFULL;
              end else begin
                h_re              = 1'b1;
                history_top_next  = top_dec;
                history_fill_next = history_fill - HCNT_W'(1);
                wq_addr_next      = queue_tail;
                queue_tail_next   = tail_inc;
                queue_fill_next   = queue_fill + QCNT_W'(1);
                pend_undo_next    = 1'b1;
                state_next        = S_WAIT;
              end
            end
            default: begin
            end
          endcase
          // Results without a RAM read are ready now.
          if (state_next == S_IDLE) begin
            out_valid_next  = 1'b1;
            out_pcount_next = queue_fill_next;
            out_hcount_next = history_fill_next;
          end
        end
      end
      S_WAIT: begin
        // Move the entry read last cycle into the other RAM.
        if (pend_undo) begin
          q_we         = 1'b1;
          q_waddr      = wq_addr;
          q_wdata      = h_rdata;
          out_id_next  = h_rdata[ENTRY_W-1:TAG_WIDTH];
          out_tag_next = h_rdata[TAG_WIDTH-1:0];
        end else begin
          h_we         = 1'b1;
          out_id_next  = q_rdata[ENTRY_W-1:TAG_WIDTH];
          out_tag_next = q_rdata[TAG_WIDTH-1:0];
        end
        out_valid_next  = 1'b1;
        out_status_next = ST_OK;
        out_pcount_next = queue_fill;
        out_hcount_next = history_fill;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, pointers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      queue_head   <= '0;
      queue_tail   <= '0;
      queue_fill   <= '0;
      history_top  <= '0;
      history_fill <= '0;
      next_id      <= ID_WIDTH'(1);
      pend_undo    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      queue_head   <= queue_head_next;
      queue_tail   <= queue_tail_next;
      queue_fill   <= queue_fill_next;
      history_top  <= history_top_next;
      history_fill <= history_fill_next;
      next_id      <= next_id_next;
      pend_undo    <= pend_undo_next;
      out_valid    <= out_valid_next;
    end
    wq_addr    <= wq_addr_next;
    wh_addr    <= wh_addr_next;
    out_id     <= out_id_next;
    out_tag    <= out_tag_next;
    out_status <= out_status_next;
    out_pcount <= out_pcount_next;
    out_hcount <= out_hcount_next;
  end

  assign rsp.valid         = out_valid;
  assign rsp.result_id     = out_id;
  assign rsp.result_tag    = out_tag;
  assign rsp.status        = out_status;
  assign rsp.pending_count = out_pcount;
  assign rsp.history_count = out_hcount;

  // Pending task RAM.
  tqu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Completed task history RAM.
  tqu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Checks on occupancy, the moves through S_WAIT, write exclusivity and the id counter.
  `ASSERT_ALWAYS(a_queue_fill, clk, rst, queue_fill <= QCNT_W'(QUEUE_DEPTH), "queue overfill")
  `ASSERT_ALWAYS(a_hist_fill, clk, rst, history_fill <= HCNT_W'(HISTORY_DEPTH), "history overfill")
  `ASSERT_NEXT(a_wait_done, clk, rst, state == S_WAIT, state == S_IDLE && out_valid, "RAM move lost")
  `ASSERT_ALWAYS(a_single_write, clk, rst, !(q_we && h_we), "both RAMs written in one cycle")
  `ASSERT_NEXT(a_next_id_nonzero, clk, rst, 1'b1, next_id != '0, "next id reached zero")

endmodule

FILE: tb/task_queue_with_undo_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task queue result checker
// Watches the request and response channels of the task queue. It keeps its
// own copy of the pending queue, the completion history and the id counter,
// predicts the result of every request transfer, and compares each response
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module task_queue_with_undo_stack_checker (
  input  logic clk,
  input  logic rst,
  tqu_req_if   req,
  tqu_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);
  import tqu_pkg::*;

  typedef struct packed {
    logic [ID_WIDTH-1:0]  id;
    logic [TAG_WIDTH-1:0] tag;
    status_t              status;
    logic [QCNT_W-1:0]    pending;
    logic [HCNT_W-1:0]    completed;
  } task_outcome_t;

  // Model of the pending queue, the completion history and the id counter.
  logic [ID_WIDTH-1:0]  pend_ids  [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0] pend_tags [QUEUE_DEPTH];
  int                   pend_head = 0;
  int                   pend_tail = 0;
  int                   pend_fill = 0;
  logic [ID_WIDTH-1:0]  done_ids  [HISTORY_DEPTH];
  logic [TAG_WIDTH-1:0] done_tags [HISTORY_DEPTH];
  int                   done_top  = 0;
  int                   done_fill = 0;
  logic [ID_WIDTH-1:0]  next_task_id = ID_WIDTH'(1);

  task_outcome_t outcome_q[$];

  // Successor of an id; zero is never handed out, so the wrap lands on one.
  function automatic logic [ID_WIDTH-1:0] id_after(input logic [ID_WIDTH-1:0] id);
    logic [ID_WIDTH-1:0] nxt;
    nxt = id + ID_WIDTH'(1);
    return (nxt == '0) ? ID_WIDTH'(1) : nxt;
  endfunction

  // Append a task at the queue tail; the caller has checked for room.
  function automatic void enqueue_task(input logic [ID_WIDTH-1:0] id,
                                       input logic [TAG_WIDTH-1:0] tag);
    pend_ids[pend_tail]  = id;
    pend_tags[pend_tail] = tag;
    pend_tail = (pend_tail + 1) % QUEUE_DEPTH;
    pend_fill++;
  endfunction

  // Apply one operation to the model and return the result it produces.
  function automatic task_outcome_t apply_task_op(input mode_t op,
                                                  input logic [ID_WIDTH-1:0] id,
                                                  input logic [TAG_WIDTH-1:0] tag);
    task_outcome_t res;
    int            slot;
    res = '0;
    res.status = ST_OK;
    case (op)
      MODE_ADD: begin
        if (pend_fill >= QUEUE_DEPTH) begin
          res.status = ST_QFULL;
        end else begin
          enqueue_task(next_task_id, tag);
          res.id  = next_task_id;
          res.tag = tag;
          next_task_id = id_after(next_task_id);
        end
      end
      MODE_RESTORE: begin
        if (pend_fill >= QUEUE_DEPTH) begin
          res.status = ST_QFULL;
        end else begin
          enqueue_task(id, tag);
          res.id  = id;
          res.tag = tag;
          if (id >= next_task_id) next_task_id = id_after(id);
        end
      end
      MODE_COMPLETE: begin
        if (pend_fill == 0) begin
          res.status = ST_QEMPTY;
        end else begin
          res.id  = pend_ids[pend_head];
          res.tag = pend_tags[pend_head];
          pend_head = (pend_head + 1) % QUEUE_DEPTH;
          pend_fill--;
          // A full history silently drops its oldest entry.
          done_ids[done_top]  = res.id;
          done_tags[done_top] = res.tag;
          done_top = (done_top + 1) % HISTORY_DEPTH;
          if (done_fill < HISTORY_DEPTH) done_fill++;
        end
      end
      default: begin
        if (done_fill == 0) begin
          res.status = ST_HEMPTY;
        end else if (pend_fill >= QUEUE_DEPTH) begin
          res.status = ST_QFULL;
        end else begin
          slot = (done_top == 0) ? HISTORY_DEPTH - 1 : done_top - 1;
          res.id  = done_ids[slot];
          res.tag = done_tags[slot];
          done_top = slot;
          done_fill--;
          enqueue_task(res.id, res.tag);
        end
      end
    endcase
    res.pending   = QCNT_W'(pend_fill);
    res.completed = HCNT_W'(done_fill);
    return res;
  endfunction

  // Compare response transfers first, then record the request transfer.
  always @(posedge clk) begin
    task_outcome_t want;
    int            errs;
    errs = 0;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no request waiting: id %h tag %h status %0d",
                 rsp.result_id, rsp.result_tag, rsp.status);
          errs++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.result_id !== want.id) begin
            $error("result_id: expected %h, got %h", want.id, rsp.result_id);
            errs++;
          end
          if (rsp.result_tag !== want.tag) begin
            $error("result_tag: expected %h, got %h", want.tag, rsp.result_tag);
            errs++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.pending_count !== want.pending) begin
            $error("pending_count: expected %0d, got %0d", want.pending,
                   rsp.pending_count);
            errs++;
          end
          if (rsp.history_count !== want.completed) begin
            $error("history_count: expected %0d, got %0d", want.completed,
                   rsp.history_count);
            errs++;
          end
        end
      end
      if (req.valid && req.ready) begin
        outcome_q.push_back(apply_task_op(mode_t'(req.mode), req.task_id, req.task_tag));
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= outcome_q.size();
  end

endmodule

FILE: tb/task_queue_with_undo_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task queue testbench
// Drives add, restore, complete and undo requests into the task queue: a
// short directed run through the id wrap, restore and empty cases, then
// random bursts that fill the queue, drain it into a full history and mix
// all operations, under several sender and receiver idle patterns and one
// long receiver hold-off. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module task_queue_with_undo_stack_tb;
  import tqu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 340;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_UNDO,
    BURST_MIXED
  } burst_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int outstanding;
  int cycle_count   = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int rx_hold_left  = 0;

  tqu_req_if req_ch();
  tqu_rsp_if rsp_ch();

  task_queue_with_undo_stack dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  task_queue_with_undo_stack_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("task_queue_with_undo_stack: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, or a held-off stretch while one is pending.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one request after a random gap and wait for its transfer.
  task automatic send_op(input mode_t op, input logic [ID_WIDTH-1:0] id,
                         input logic [TAG_WIDTH-1:0] tag);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= op;
    req_ch.task_id  <= id;
    req_ch.task_tag <= tag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Restore ids lean toward small values and the top of the range.
  function automatic logic [ID_WIDTH-1:0] pick_id();
    case ($urandom_range(3))
      0:       return ID_WIDTH'($urandom_range(15));
      1:       return ID_WIDTH'($urandom_range((1 << ID_WIDTH) - 1, (1 << ID_WIDTH) - 16));
      default: return ID_WIDTH'($urandom());
    endcase
  endfunction

  // Operation mix per burst kind.
  function automatic mode_t pick_op(input burst_kind_t kind);
    int roll;
    roll = $urandom_range(99);
    case (kind)
      BURST_FILL:  return (roll < 60) ? MODE_ADD : (roll < 90) ? MODE_RESTORE : MODE_UNDO;
      BURST_DRAIN: return (roll < 90) ? MODE_COMPLETE : MODE_ADD;
      BURST_UNDO:  return (roll < 60) ? MODE_UNDO : (roll < 90) ? MODE_COMPLETE : MODE_ADD;
      default:     return mode_t'(roll % 4);
    endcase
  endfunction

  // Random bursts; with open_with_fill the first two fill the queue and then drain it.
  task automatic run_bursts(input int count, input bit open_with_fill);
    burst_kind_t kind;
    int          len;
    int          sent;
    int          burst_no;
    sent = 0;
    burst_no = 0;
    while (sent < count) begin
      if (open_with_fill && burst_no < 2) begin
        kind = (burst_no == 0) ? BURST_FILL : BURST_DRAIN;
        len  = 72;
      end else begin
        kind = burst_kind_t'($urandom_range(3));
        len  = $urandom_range(80, 8);
      end
      for (int i = 0; i < len && sent < count; i++) begin
        send_op(pick_op(kind), pick_id(), $urandom());
        sent++;
      end
      burst_no++;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_ADD;
    req_ch.task_id  = '0;
    req_ch.task_tag = '0;
    rsp_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, restore rules and the id wrap.
    send_op(MODE_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(MODE_UNDO,     16'h0000, 32'h0000_0000);
    send_op(MODE_ADD,      16'hFFFF, 32'h0000_0000);
    send_op(MODE_ADD,      16'h0000, 32'hFFFF_FFFF);
    send_op(MODE_RESTORE,  16'h0000, 32'h5A5A_5A5A);
    send_op(MODE_RESTORE,  16'h0003, 32'hA5A5_A5A5);
    send_op(MODE_RESTORE,  16'h0002, $urandom());
    send_op(MODE_RESTORE,  16'hFFFE, $urandom());
    send_op(MODE_ADD,      16'h1234, $urandom());
    send_op(MODE_ADD,      16'h0000, $urandom());
    send_op(MODE_RESTORE,  16'hFFFF, $urandom());
    send_op(MODE_ADD,      16'h0000, $urandom());
    send_op(MODE_COMPLETE, 16'h0000, $urandom());
    send_op(MODE_COMPLETE, 16'h0000, $urandom());
    send_op(MODE_UNDO,     16'h0000, $urandom());
    send_op(MODE_UNDO,     16'h0000, $urandom());
    send_op(MODE_UNDO,     16'h0000, $urandom());
    send_op(MODE_RESTORE,  16'h0001, $urandom());
    send_op(MODE_COMPLETE, 16'hFFFF, $urandom());

    // Random phases under different idle patterns.
    run_bursts(ITEMS_PER_PHASE, 1'b1);
    tx_idle_pct  = 86;
    run_bursts(ITEMS_PER_PHASE, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 86;
    run_bursts(ITEMS_PER_PHASE, 1'b1);
    tx_idle_pct  = 6;
    rx_stall_pct = 6;
    run_bursts(ITEMS_PER_PHASE, 1'b0);

    // Long receiver hold-off while requests keep coming back to back.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 200;
    run_bursts(30, 1'b0);

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("task_queue_with_undo_stack: match");
    end else begin
      $display("task_queue_with_undo_stack: mismatch");
    end
    $finish;
  end

endmodule
